// ===== rtl/mfwd_pkg.sv =====
package mfwd_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int WEIGHT_W       = 16;
  localparam int SUM_W          = 64;
  localparam int MIS_W          = 40;
  localparam int DIST_W         = 48;
  localparam int FRAC_SHIFT     = 8;
  localparam int ARG_W          = 56;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic MODE_EUCLID    = 1'b0;
  localparam logic MODE_MANHATTAN = 1'b1;

  localparam logic [SUM_W-1:0]  ROOT_PROBE_INIT = 64'h4000_0000_0000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX        = '1;
  localparam logic [ARG_W-1:0]  ARG_MAX         = '1;

  typedef struct packed {
    logic numeric;
    logic mismatch;
    logic last;
    logic mode;
  } item_ctl_t;

  typedef struct packed {
    logic start;
    logic sat;
    logic mode;
  } fin_ctl_t;

endpackage

// ===== rtl/mfwd_queue.sv =====
module mfwd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mfwd_front.sv =====
module mfwd_front
  import mfwd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] train_value,
  input  logic signed [VALUE_BITS-1:0] test_value,
  input  logic        [WEIGHT_W-1:0]   feature_weight,
  input  logic                         is_numeric,
  input  logic                         last_feature,
  input  logic                         mode,
  input  logic                         q_full,
  output logic                         q_push,
  output logic        [VALUE_BITS-1:0] abs_diff,
  output logic        [WEIGHT_W-1:0]   weight,
  output item_ctl_t                    ctl
);

  logic [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0] mag;

  assign diff = {train_value[VALUE_BITS-1], train_value}
              - {test_value[VALUE_BITS-1], test_value};
  assign mag  = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;

  assign abs_diff     = mag[VALUE_BITS-1:0];
  assign weight       = feature_weight;
  assign ctl.numeric  = is_numeric;
  assign ctl.mismatch = (train_value != test_value);
  assign ctl.last     = last_feature;
  assign ctl.mode     = mode;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/mfwd_back.sv =====
module mfwd_back
  import mfwd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [VALUE_BITS-1:0] q_abs_diff,
  input  logic [WEIGHT_W-1:0]   q_weight,
  input  item_ctl_t             q_ctl,
  output logic                  q_pop,
  input  logic                  root_busy,
  output fin_ctl_t              fin,
  output logic [SUM_W-1:0]      fin_num,
  output logic [MIS_W-1:0]      fin_mis
);

  localparam int SQ_W   = 2 * VALUE_BITS;
  localparam int PROD_W = WEIGHT_W + VALUE_BITS;
  localparam int TERM_W = WEIGHT_W + SQ_W;

  logic                  s1_valid;
  item_ctl_t             s1_ctl;
  logic [VALUE_BITS-1:0] s1_ad;
  logic [SQ_W-1:0]       s1_sq;
  logic [WEIGHT_W-1:0]   s1_w;

  logic                  s2_valid;
  item_ctl_t             s2_ctl;
  logic [PROD_W-1:0]     s2_lo;
  logic [PROD_W-1:0]     s2_hi;
  logic [WEIGHT_W-1:0]   s2_w;

  logic                  s3_valid;
  item_ctl_t             s3_ctl;
  logic [TERM_W-1:0]     s3_term;
  logic [WEIGHT_W-1:0]   s3_w;

  logic [SUM_W-1:0]      numeric_sum;
  logic [MIS_W-1:0]      mismatch_sum;
  logic                  overflow_seen;

  logic [SUM_W-1:0]      numeric_sum_next;
  logic [MIS_W-1:0]      mismatch_sum_next;
  logic                  overflow_seen_next;

  logic                  last_busy;
  logic [SQ_W-1:0]       mul_src;
  logic [SUM_W:0]        num_add;
  logic [MIS_W:0]        mis_add;
  logic                  s3_last;

  // hold a row end back while the previous row end is still being finished
  assign last_busy = (s1_valid && s1_ctl.last) || (s2_valid && s2_ctl.last)
                   || (s3_valid && s3_ctl.last) || fin.start || root_busy;
  assign q_pop     = !q_empty && !(q_ctl.last && last_busy);

  assign mul_src = (s1_ctl.mode == MODE_MANHATTAN) ? SQ_W'(s1_ad) : s1_sq;
  assign num_add = {1'b0, numeric_sum} + (SUM_W + 1)'(s3_term);
  assign mis_add = {1'b0, mismatch_sum} + (MIS_W + 1)'(s3_w);
  assign s3_last = s3_valid && s3_ctl.last;

  always_comb begin
    numeric_sum_next   = numeric_sum;
    mismatch_sum_next  = mismatch_sum;
    overflow_seen_next = overflow_seen;
    if (s3_valid) begin
      if (s3_ctl.numeric) begin
        numeric_sum_next   = num_add[SUM_W] ? '1 : num_add[SUM_W-1:0];
        overflow_seen_next = overflow_seen || num_add[SUM_W];
      end else if (s3_ctl.mismatch) begin
        mismatch_sum_next  = mis_add[MIS_W] ? '1 : mis_add[MIS_W-1:0];
        overflow_seen_next = overflow_seen || mis_add[MIS_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl  <= q_ctl;
    s1_ad   <= q_abs_diff;
    s1_sq   <= SQ_W'(q_abs_diff) * SQ_W'(q_abs_diff);
    s1_w    <= q_weight;
    s2_ctl  <= s1_ctl;
    s2_lo   <= PROD_W'(s1_w) * PROD_W'(mul_src[VALUE_BITS-1:0]);
    s2_hi   <= PROD_W'(s1_w) * PROD_W'(mul_src[SQ_W-1:VALUE_BITS]);
    s2_w    <= s1_w;
    s3_ctl  <= s2_ctl;
    s3_term <= TERM_W'(s2_lo) + (TERM_W'(s2_hi) << VALUE_BITS);
    s3_w    <= s2_w;
    if (s3_last) begin
      fin_num  <= numeric_sum_next;
      fin_mis  <= mismatch_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      numeric_sum   <= '0;
      mismatch_sum  <= '0;
      overflow_seen <= 1'b0;
      fin.start     <= 1'b0;
    end else begin
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      fin.start <= s3_last;
      if (s3_last) begin
        fin.sat       <= overflow_seen_next;
        fin.mode      <= s3_ctl.mode;
        numeric_sum   <= '0;
        mismatch_sum  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        numeric_sum   <= numeric_sum_next;
        mismatch_sum  <= mismatch_sum_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

// ===== rtl/mfwd_root.sv =====
module mfwd_root
  import mfwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  fin_ctl_t          fin,
  input  logic [SUM_W-1:0]  fin_num,
  input  logic [MIS_W-1:0]  fin_mis,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] distance,
  output logic              saturated
);

  typedef enum logic [2:0] {
    IDLE,
    ARG,
    ROOT,
    CLAMP,
    SUM
  } state_t;

  state_t            state;
  logic              mode;
  logic              sat;
  logic [SUM_W-1:0]  rest;
  logic [SUM_W-1:0]  root;
  logic [SUM_W-1:0]  probe;
  logic [DIST_W-1:0] num_part;

  logic [SUM_W-1:0]  trial;
  logic              arg_big;
  logic [ARG_W-1:0]  arg;
  logic [SUM_W-1:0]  clamp_src;
  logic [DIST_W:0]   total;
  logic              out_free;
  logic              out_load;

  assign busy      = (state != IDLE);
  assign trial     = root + probe;
  assign arg_big   = |fin_num[SUM_W-1:ARG_W];
  assign arg       = arg_big ? ARG_MAX : fin_num[ARG_W-1:0];
  assign clamp_src = (mode == MODE_MANHATTAN) ? fin_num : root;
  assign total     = {1'b0, num_part} + {1'b0, fin_mis, {FRAC_SHIFT{1'b0}}};
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == SUM) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (fin.start) begin
            mode  <= fin.mode;
            sat   <= fin.sat;
            state <= ARG;
          end
        end
        ARG: begin
          if (mode == MODE_EUCLID) begin
            rest  <= {arg, {FRAC_SHIFT{1'b0}}};
            root  <= '0;
            probe <= ROOT_PROBE_INIT;
            sat   <= sat || arg_big;
            state <= ROOT;
          end else begin
            state <= CLAMP;
          end
        end
        ROOT: begin
          if (rest >= trial) begin
            rest <= rest - trial;
            root <= (root >> 1) + probe;
          end else begin
            root <= root >> 1;
          end
          probe <= probe >> 2;
          if (probe[0]) begin
            state <= CLAMP;
          end
        end
        CLAMP: begin
          if (|clamp_src[SUM_W-1:DIST_W]) begin
            num_part <= DIST_MAX;
            sat      <= 1'b1;
          end else begin
            num_part <= clamp_src[DIST_W-1:0];
          end
          state <= SUM;
        end
        SUM: begin
          if (out_free) begin
            distance  <= total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];
            saturated <= sat || total[DIST_W];
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mixed_feature_weighted_distance.sv =====
// A row's last word passes the queue, stages s1 to s3 and the finisher (ARG, ROOT for Euclidean only, CLAMP, SUM).
// Throughput: one feature word per cycle while in_stall is low; rows overlap, except that a row's last
// word waits in the queue until the previous row's result is loaded.
// The Euclidean path runs a one-bit-per-cycle square root (32 steps).
// Reset (rst, synchronous): clears sums, queue and pipeline; mode returns to Manhattan.
module mixed_feature_weighted_distance
  import mfwd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] train_value,
  input  logic signed [VALUE_BITS-1:0] test_value,
  input  logic        [WEIGHT_W-1:0]   feature_weight,
  input  logic                         is_numeric,
  input  logic                         last_feature,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [DIST_W-1:0]     distance,
  output logic                         saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         distance_mode
);

  localparam int QW = VALUE_BITS + WEIGHT_W + $bits(item_ctl_t);

  logic                  mode;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_empty;
  logic                  q_full;
  logic [QW-1:0]         q_din;
  logic [QW-1:0]         q_dout;
  logic [VALUE_BITS-1:0] f_abs_diff;
  logic [WEIGHT_W-1:0]   f_weight;
  item_ctl_t             f_ctl;
  logic [VALUE_BITS-1:0] h_abs_diff;
  logic [WEIGHT_W-1:0]   h_weight;
  item_ctl_t             h_ctl;
  fin_ctl_t              fin;
  logic [SUM_W-1:0]      fin_num;
  logic [MIS_W-1:0]      fin_mis;
  logic                  root_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MANHATTAN;
    end else if (cfg_valid && cfg_ready) begin
      mode <= distance_mode;
    end
  end

  mfwd_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .train_value    (train_value),
    .test_value     (test_value),
    .feature_weight (feature_weight),
    .is_numeric     (is_numeric),
    .last_feature   (last_feature),
    .mode           (mode),
    .q_full         (q_full),
    .q_push         (q_push),
    .abs_diff       (f_abs_diff),
    .weight         (f_weight),
    .ctl            (f_ctl)
  );

  assign q_din = {f_abs_diff, f_weight, f_ctl};
  assign {h_abs_diff, h_weight, h_ctl} = q_dout;

  mfwd_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  mfwd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_abs_diff (h_abs_diff),
    .q_weight   (h_weight),
    .q_ctl      (h_ctl),
    .q_pop      (q_pop),
    .root_busy  (root_busy),
    .fin        (fin),
    .fin_num    (fin_num),
    .fin_mis    (fin_mis)
  );

  mfwd_root u_root (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .fin_num   (fin_num),
    .fin_mis   (fin_mis),
    .busy      (root_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .distance  (distance),
    .saturated (saturated)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    fin.start |-> !root_busy)
    else $error("row end issued while finisher busy");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    fin.start |=> root_busy)
    else $error("row end dropped by finisher");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(root_busy))
    else $error("result word without a finished row");

endmodule

// ===== bench/mfwd_checker.sv =====
module mfwd_checker
  import mfwd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] train_value,
  input  logic signed [VALUE_BITS-1:0] test_value,
  input  logic        [WEIGHT_W-1:0]   feature_weight,
  input  logic                         is_numeric,
  input  logic                         last_feature,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic        [DIST_W-1:0]     distance,
  input  logic                         saturated,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         distance_mode,
  output int                           error_count,
  output int                           pending_rows
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MIS_LIMIT = (64'd1 << MIS_W) - 64'd1;

  typedef struct packed {
    logic [DIST_W-1:0] row_dist;
    logic              sat;
  } row_result_t;

  row_result_t row_distance_q[$];
  row_result_t want;

  logic        cur_mode;
  logic [63:0] numeric_acc;
  logic [63:0] category_acc;
  logic        row_overflow;
  int          errs;

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = x;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic accumulate_feature(input logic signed [VALUE_BITS-1:0] tv,
                                    input logic signed [VALUE_BITS-1:0] sv,
                                    input logic [WEIGHT_W-1:0] w, input logic num);
    longint       diff;
    logic [63:0]  mag;
    logic [63:0]  term;
    logic [127:0] w_ext;
    logic [127:0] sq_ext;
    logic [127:0] wide;
    logic [64:0]  sum;
    if (num) begin
      diff = tv - sv;
      mag  = (diff < 0) ? -diff : diff;
      if (cur_mode == MODE_MANHATTAN) begin
        term = mag * w;
      end else begin
        w_ext  = w;
        sq_ext = mag * mag;
        wide   = w_ext * sq_ext;
        if (wide[127:64] != 0) begin
          term         = '1;
          row_overflow = 1'b1;
        end else begin
          term = wide[63:0];
        end
      end
      sum = {1'b0, numeric_acc} + {1'b0, term};
      if (sum[64]) begin
        numeric_acc  = '1;
        row_overflow = 1'b1;
      end else begin
        numeric_acc = sum[63:0];
      end
    end else if (tv != sv) begin
      category_acc = category_acc + w;
      if (category_acc > MIS_LIMIT) begin
        category_acc = MIS_LIMIT;
        row_overflow = 1'b1;
      end
    end
  endtask

  task automatic close_row;
    row_result_t r;
    logic [63:0] arg;
    logic [63:0] part;
    logic [63:0] total;
    r.sat = row_overflow;
    if (cur_mode == MODE_MANHATTAN) begin
      part = numeric_acc;
    end else begin
      arg = numeric_acc;
      if (arg > ARG_MAX) begin
        arg   = ARG_MAX;
        r.sat = 1'b1;
      end
      part = floor_root(arg << FRAC_SHIFT);
    end
    if (part > DIST_MAX) begin
      part  = DIST_MAX;
      r.sat = 1'b1;
    end
    total = part + (category_acc << FRAC_SHIFT);
    if (total > DIST_MAX) begin
      total = DIST_MAX;
      r.sat = 1'b1;
    end
    r.row_dist = total[DIST_W-1:0];
    row_distance_q = {row_distance_q, r};
    numeric_acc  = '0;
    category_acc = '0;
    row_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode     = MODE_MANHATTAN;
      numeric_acc  = '0;
      category_acc = '0;
      row_overflow = 1'b0;
      errs         = 0;
      row_distance_q.delete();
      pending_rows <= 0;
      error_count  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (row_distance_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result word: distance=%0d saturated=%0b", distance, saturated);
        end else begin
          want = row_distance_q.pop_front();
          if (distance !== want.row_dist || saturated !== want.sat) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected distance=%0d saturated=%0b, got distance=%0d saturated=%0b",
                       want.row_dist, want.sat, distance, saturated);
          end
        end
      end
      if (in_valid && !in_stall) begin
        accumulate_feature(train_value, test_value, feature_weight, is_numeric);
        if (last_feature) close_row();
      end
      if (cfg_valid && cfg_ready) cur_mode = distance_mode;
      pending_rows <= row_distance_q.size();
      error_count  <= errs;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import mfwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int DRAIN       = 64;
  localparam int DRAIN_LIMIT = 200000;
  localparam int LONG_ROW    = 280;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 125;
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic signed [VB-1:0]  train_value    = '0;
  logic signed [VB-1:0]  test_value     = '0;
  logic [WEIGHT_W-1:0]   feature_weight = '0;
  logic                  is_numeric     = 1'b0;
  logic                  last_feature   = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [DIST_W-1:0]     distance;
  logic                  saturated;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic                  distance_mode  = MODE_MANHATTAN;

  int error_count;
  int pending_rows;
  int burst_left = 1;
  int gap_max    = 8;
  int row_left   = 0;
  int stall_left = 0;
  int stall_style = 0;

  always #6 clk = ~clk;

  mixed_feature_weighted_distance #(.VALUE_BITS(VB)) u_dut (
    .clk, .rst, .in_valid, .in_stall, .train_value, .test_value, .feature_weight,
    .is_numeric, .last_feature, .out_valid, .out_stall, .distance, .saturated,
    .cfg_valid, .cfg_ready, .distance_mode
  );

  mfwd_checker #(.VALUE_BITS(VB)) u_checker (
    .clk, .rst, .in_valid, .in_stall, .train_value, .test_value, .feature_weight,
    .is_numeric, .last_feature, .out_valid, .out_stall, .distance, .saturated,
    .cfg_valid, .cfg_ready, .distance_mode, .error_count, .pending_rows
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 16 < 5);
    endcase
  end

  function automatic logic signed [VB-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VMIN;
      1:       return VMAX;
      2:       return '0;
      3:       return VB'($signed($urandom_range(0, 511)) - 256);
      default: return VB'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h0100;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic signed [VB-1:0] tv, input logic signed [VB-1:0] sv,
                           input logic [WEIGHT_W-1:0] w, input logic num, input logic lst);
    int gap;
    train_value    <= tv;
    test_value     <= sv;
    feature_weight <= w;
    is_numeric     <= num;
    last_feature   <= lst;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, gap_max);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle;
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_valid     <= 1'b1;
    distance_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_words(input int n);
    logic                 num;
    logic signed [VB-1:0] tv;
    logic signed [VB-1:0] sv;
    for (int i = 0; i < n; i++) begin
      if (row_left == 0)
        row_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      row_left--;
      num = ($urandom_range(0, 2) != 0);
      tv  = pick_value();
      sv  = (!num && $urandom_range(0, 1)) ? tv : pick_value();
      send_word(tv, sv, pick_weight(), num, row_left == 0);
    end
  endtask

  initial begin
    #(12ns * 4000000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic m;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_MANHATTAN);
    send_word(VMAX, VMIN, 16'hFFFF, 1'b1, 1'b1);
    send_word(VMIN, VMAX, 16'hFFFF, 1'b0, 1'b0);
    send_word(VMAX, VMAX, 16'hFFFF, 1'b0, 1'b0);
    send_word(VMIN, VMAX, 16'h0000, 1'b1, 1'b0);
    send_word(16'sd1, 16'sd2, 16'h0000, 1'b0, 1'b1);
    send_word(16'sd0, 16'sd0, 16'h0000, 1'b1, 1'b1);
    send_word(VMIN, VMIN, 16'h0100, 1'b1, 1'b0);
    send_word(16'sd256, -16'sd256, 16'h0100, 1'b1, 1'b1);
    write_mode(MODE_EUCLID);
    send_word(VMIN, VMAX, 16'hFFFF, 1'b1, 1'b1);
    send_word(16'sd3, 16'sd1, 16'h0100, 1'b1, 1'b0);
    send_word(16'sd5, -16'sd7, 16'h0080, 1'b0, 1'b0);
    send_word(16'sd0, 16'sd0, 16'hFFFF, 1'b1, 1'b1);
    send_word(VMAX, VMIN, 16'h0001, 1'b0, 1'b1);
    send_word(-16'sd1, 16'sd0, 16'h0001, 1'b1, 1'b1);
    // switch mode between words of one row
    send_word(16'sd100, -16'sd100, 16'h0200, 1'b1, 1'b0);
    write_mode(MODE_MANHATTAN);
    send_word(16'sd100, -16'sd100, 16'h0200, 1'b1, 1'b0);
    write_mode(MODE_EUCLID);
    send_word(16'sd1, 16'sd2, 16'h0300, 1'b0, 1'b1);
    send_word(-16'sd50, 16'sd50, 16'h0100, 1'b1, 1'b0);
    write_mode(MODE_MANHATTAN);
    send_word(16'sd10, 16'sd0, 16'h0100, 1'b1, 1'b0);
    write_mode(MODE_EUCLID);
    send_word(16'sd0, 16'sd0, 16'h0100, 1'b0, 1'b1);

    // saturate the root argument, then run a long Manhattan row
    gap_max = 1;
    write_mode(MODE_EUCLID);
    repeat (LONG_ROW) send_word(VMAX, VMIN, 16'hFFFF, 1'b1, 1'b0);
    send_word(VMAX, VMIN, 16'hFFFF, 1'b1, 1'b1);
    write_mode(MODE_MANHATTAN);
    repeat (LONG_ROW) send_word(VMIN, VMAX, 16'hFFFF, 1'b1, 1'b0);
    send_word(VMIN, VMAX, 16'hFFFF, 1'b1, 1'b1);
    gap_max = 8;

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        m = MODE_EUCLID;
      else if (p == 1)
        m = MODE_MANHATTAN;
      else
        m = 1'($urandom_range(0, 1));
      write_mode(m);
      random_words(PHASE_WORDS);
    end
    if (row_left != 0) begin
      row_left = 1;
      random_words(1);
    end

    settle();
    if (error_count == 0 && pending_rows == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mfwd_pkg.sv
rtl/mfwd_queue.sv
rtl/mfwd_front.sv
rtl/mfwd_back.sv
rtl/mfwd_root.sv
rtl/mixed_feature_weighted_distance.sv
bench/mfwd_checker.sv
bench/tb_top.sv
